>>> src/bbar_pkg.sv
package bbar_pkg;

  // Fixed field widths of the payload and the configuration registers.
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned OFFS_W         = 31;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned WIDTH_BITS     = 5;
  localparam int unsigned WIDTH_REG_BITS = 20;
  localparam int unsigned SCALE_REG_BITS = 64;
  localparam int unsigned BLOCK_W        = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTHS = 3'd0,
    CFG_DST_WIDTHS = 3'd1,
    CFG_SRC_SCALES = 3'd2,
    CFG_DST_SCALES = 3'd3,
    CFG_BLOCK_SIZE = 3'd4,
    CFG_BUF_SIZE   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [WIDTH_REG_BITS-1:0] src_widths;
    logic [WIDTH_REG_BITS-1:0] dst_widths;
    logic [SCALE_REG_BITS-1:0] src_scales;
    logic [SCALE_REG_BITS-1:0] dst_scales;
    logic [BLOCK_W-1:0]        block_size;
    logic [ADDR_W-1:0]         buffer_size;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  move_counter;
    logic [OFFS_W-1:0] base_offset;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic              bounds_fault;
  } out_t;

endpackage

>>> src/bbar_cfg.sv
module bbar_cfg
  import bbar_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes leave the registers alone.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTHS: cfg_d.src_widths  = cfg_data_i[WIDTH_REG_BITS-1:0];
        CFG_DST_WIDTHS: cfg_d.dst_widths  = cfg_data_i[WIDTH_REG_BITS-1:0];
        CFG_SRC_SCALES: cfg_d.src_scales  = cfg_data_i[SCALE_REG_BITS-1:0];
        CFG_DST_SCALES: cfg_d.dst_scales  = cfg_data_i[SCALE_REG_BITS-1:0];
        CFG_BLOCK_SIZE: cfg_d.block_size  = cfg_data_i[BLOCK_W-1:0];
        CFG_BUF_SIZE:   cfg_d.buffer_size = cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bbar_lane.sv
module bbar_lane
  import bbar_pkg::*;
#(
  parameter int unsigned SHIFT_W    = 8,
  parameter int unsigned SCALE_BITS = 16
) (
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [SHIFT_W-1:0]    shift_i,
  input  logic [WIDTH_BITS-1:0] width_i,
  input  logic [SCALE_BITS-1:0] scale_i,
  output logic [ADDR_W-1:0]     prod_o
);

  localparam int unsigned PROD_W = CNT_W + SCALE_BITS;

  logic [CNT_W-1:0]  mask;
  logic [CNT_W-1:0]  shifted;
  logic [CNT_W-1:0]  field;
  logic [PROD_W-1:0] full;

  // A zero width gives an empty mask, so the channel adds nothing.
  assign mask = CNT_W'((33'd1 << width_i) - 33'd1);

  // A field that starts at or above bit 32 reads as zero.
  assign shifted = (|shift_i[SHIFT_W-1:5]) ? '0 : (cnt_i >> shift_i[4:0]);
  assign field   = shifted & mask;

  // Only the low address bits of the product are kept.
  assign full   = PROD_W'(field) * PROD_W'(scale_i);
  assign prod_o = full[ADDR_W-1:0];

endmodule

>>> src/bitfield_block_address_remapper_top.sv
// Bit-field block address remapper. Each transfer on the input channel carries a
// move counter and a base offset; the counter is cut into CHANNELS bit fields per side,
// with the last channel in the least significant bits, each field is scaled by its
// channel multiplier, and the sums plus the offset give a source and a destination block
// address, together with a bounds fault flag. The block takes one item per cycle while the
// output is not stalled. The accepting edge loads the per-channel field products, the two
// address sums are then registered, and after them the output register is loaded with the
// bounds check. Stages with a bubble keep filling while the output is stalled.
// Configuration is written through its own port while no item is in flight; the user must
// keep to this, as the block itself does not enforce it.
module bitfield_block_address_remapper_top
  import bbar_pkg::*;
#(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned SCALE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int unsigned SHIFT_W = $clog2(CHANNELS * 31 + 33);
  localparam int unsigned PAD_W   = SCALE_REG_BITS + CHANNELS * SCALE_BITS;

  cfg_t cfg;

  bbar_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Per-channel widths and scales; channels past the packed register bits read as zero.
  logic [WIDTH_BITS-1:0] src_w [CHANNELS];
  logic [WIDTH_BITS-1:0] dst_w [CHANNELS];
  logic [SCALE_BITS-1:0] src_s [CHANNELS];
  logic [SCALE_BITS-1:0] dst_s [CHANNELS];
  logic [PAD_W-1:0]      src_pad;
  logic [PAD_W-1:0]      dst_pad;

  assign src_pad = {{(CHANNELS * SCALE_BITS){1'b0}}, cfg.src_scales};
  assign dst_pad = {{(CHANNELS * SCALE_BITS){1'b0}}, cfg.dst_scales};

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan_cfg
    if ((ch + 1) * WIDTH_BITS <= WIDTH_REG_BITS) begin : g_w
      assign src_w[ch] = cfg.src_widths[ch*WIDTH_BITS +: WIDTH_BITS];
      assign dst_w[ch] = cfg.dst_widths[ch*WIDTH_BITS +: WIDTH_BITS];
    end else begin : g_w_none
      assign src_w[ch] = '0;
      assign dst_w[ch] = '0;
    end
    assign src_s[ch] = src_pad[ch*SCALE_BITS +: SCALE_BITS];
    assign dst_s[ch] = dst_pad[ch*SCALE_BITS +: SCALE_BITS];
  end

  // Field positions: each channel sits right above the channels after it.
  logic [SHIFT_W-1:0] src_sh [CHANNELS];
  logic [SHIFT_W-1:0] dst_sh [CHANNELS];

  always_comb begin
    logic [SHIFT_W-1:0] src_acc;
    logic [SHIFT_W-1:0] dst_acc;
    src_acc = '0;
    dst_acc = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      src_sh[i] = src_acc;
      dst_sh[i] = dst_acc;
      src_acc   = src_acc + SHIFT_W'(src_w[i]);
      dst_acc   = dst_acc + SHIFT_W'(dst_w[i]);
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor moves on.
  logic v1_q, v2_q, out_valid_q;
  logic ready1, ready2, ready3;

  assign ready3     = !out_valid_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  // Stage 1: field products for every channel of both sides.
  logic [ADDR_W-1:0] src_prod [CHANNELS];
  logic [ADDR_W-1:0] dst_prod [CHANNELS];
  logic [ADDR_W-1:0] src_prod_q [CHANNELS];
  logic [ADDR_W-1:0] dst_prod_q [CHANNELS];
  logic [OFFS_W-1:0] offs1_q;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    bbar_lane #(
      .SHIFT_W    (SHIFT_W),
      .SCALE_BITS (SCALE_BITS)
    ) u_src_lane (
      .cnt_i   (in_data_i.move_counter),
      .shift_i (src_sh[ch]),
      .width_i (src_w[ch]),
      .scale_i (src_s[ch]),
      .prod_o  (src_prod[ch])
    );

    bbar_lane #(
      .SHIFT_W    (SHIFT_W),
      .SCALE_BITS (SCALE_BITS)
    ) u_dst_lane (
      .cnt_i   (in_data_i.move_counter),
      .shift_i (dst_sh[ch]),
      .width_i (dst_w[ch]),
      .scale_i (dst_s[ch]),
      .prod_o  (dst_prod[ch])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      src_prod_q <= src_prod;
      dst_prod_q <= dst_prod;
      offs1_q    <= in_data_i.base_offset;
    end
  end

  // Stage 2: sum the products and the offset, modulo 2^32.
  logic [ADDR_W-1:0] sa_d, da_d, sa_q, da_q;

  always_comb begin
    sa_d = ADDR_W'(offs1_q);
    da_d = ADDR_W'(offs1_q);
    for (int i = 0; i < CHANNELS; i++) begin
      sa_d = sa_d + src_prod_q[i];
      da_d = da_d + dst_prod_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      sa_q <= sa_d;
      da_q <= da_d;
    end
  end

  // Stage 3: bounds check and the output register.
  logic [ADDR_W-1:0] avail;
  logic              fault;
  out_t              out_q;

  assign avail = cfg.buffer_size - ADDR_W'(cfg.block_size);
  assign fault = (ADDR_W'(cfg.block_size) >= cfg.buffer_size) || (sa_q > avail) ||
                 (da_q > avail);

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q) begin
      out_q.source_address <= sa_q;
      out_q.dest_address   <= da_q;
      out_q.bounds_fault   <= fault;
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        out_valid_q <= v2_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted transfer always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted input did not reach stage one");

  // Input stalls only when every stage is occupied and the output is held.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && out_valid_q && out_stall_i)
    else $error("input stalled with a free stage");

  // A sum that moves on shows up unchanged in the output register.
  a_sum_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && ready3 |=> out_valid_q && out_data_o.source_address == $past(sa_q) &&
    out_data_o.dest_address == $past(da_q))
    else $error("stage two result lost on its way to the output");

endmodule
